/* src/rmj_pkg.sv */
// Shared types, constants and rounding helpers for the radar measurement Jacobian block.
// No dependencies; every other file in src imports this package.
package rmj_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } item_t;

  typedef struct packed {
    logic signed [31:0] range_dx;
    logic signed [31:0] range_dy;
    logic signed [31:0] bearing_dx;
    logic signed [31:0] bearing_dy;
    logic signed [31:0] rate_dx;
    logic signed [31:0] rate_dy;
    logic               near_origin;
    logic               saturated;
  } result_t;

  localparam int LIMIT_W = 17;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd66;

  // Divider geometry: dividend, divisor and quotient widths.
  localparam int DVD_W   = 128;
  localparam int DVS_W   = 64;
  localparam int QUO_W   = 33;
  localparam int DIV_LAT = QUO_W + 1;

  localparam int ROOT_W = 32;

  localparam logic [QUO_W-1:0] CAP_POS = 33'h0_7FFF_FFFF;
  localparam logic [QUO_W-1:0] CAP_NEG = 33'h0_8000_0000;

  // The quotient carries one extra fraction bit; fold it in to round halves up.
  function automatic logic [QUO_W-1:0] round_q(input logic [QUO_W-1:0] q);
    round_q = {1'b0, q[QUO_W-1:1]} + {{(QUO_W-1){1'b0}}, q[0]};
  endfunction

  // Returns {saturated, signed 32-bit value}.
  function automatic logic [32:0] clip_out(input logic [QUO_W-1:0] q, input logic ovf,
                                           input logic neg);
    logic [QUO_W-1:0] rnd;
    logic [QUO_W-1:0] cap;
    logic [QUO_W-1:0] mag;
    logic             sat;
    rnd = round_q(q);
    cap = neg ? CAP_NEG : CAP_POS;
    sat = ovf || (rnd > cap);
    mag = sat ? cap : rnd;
    clip_out = {sat, neg ? (32'd0 - mag[31:0]) : mag[31:0]};
  endfunction

endpackage

/* src/radar_measurement_jacobian_core.sv */
// Radar measurement Jacobian: range, bearing and range-rate derivatives of a CV state.
// Depends on rmj_pkg and rmj_div.
//
// Usage: the item channel takes one state word (pos_x, pos_y, vel_x, vel_y, signed
// fixed point with FRAC_BITS fraction bits) under item_valid / item_stall. The result
// channel gives one Jacobian word per state under result_valid / result_stall. The
// near-zero limit is written through cfg_valid / cfg_data; cfg_ready is always high.
// One word can enter every cycle while the receiver does not stall with a result
// waiting. The pipeline is made of the 32-stage square root, the 34-stage dividers
// that form px/r and py/r, and the 34-stage dividers for the bearing and rate terms.
// When the receiver stalls with a result waiting, the whole pipeline holds; an empty
// first stage still takes a new word, so nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits and loads the limit with 66.
module radar_measurement_jacobian_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  rmj_pkg::item_t             item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output rmj_pkg::result_t           result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rmj_pkg::LIMIT_W-1:0] cfg_data
);
  import rmj_pkg::*;

  localparam int RX_W   = FRAC_BITS + 2;
  localparam int PP_W   = RX_W + 32;
  localparam int N_W    = RX_W + 64;
  localparam int NSTAGE = 4 + ROOT_W + DIV_LAT + 4 + DIV_LAT;

  typedef struct packed {
    logic        near;
    logic        sp;
    logic        sq;
    logic        sw;
    logic [4:0]  e;
    logic [31:0] a_n;
    logic [31:0] b_n;
    logic [63:0] s_sum;
    logic [63:0] wm;
  } ctx_t;

  typedef struct packed {
    logic        near;
    logic        sat;
    logic        neg_bx;
    logic        neg_by;
    logic        neg_rx;
    logic        neg_ry;
    logic [31:0] rdx;
    logic [31:0] rdy;
  } ctxb_t;

  // ---------------- control ----------------
  logic [NSTAGE-1:0]  vld;
  logic               adv;
  logic               load0;
  logic [LIMIT_W-1:0] limit;

  assign adv        = !result_valid || !result_stall;
  assign load0      = adv || !vld[0];
  assign item_stall = !load0;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result_valid <= 1'b0;
      limit        <= LIMIT_RESET;
    end else begin
      if (cfg_valid) begin
        limit <= cfg_data;
      end
      if (load0) begin
        vld[0] <= item_valid;
      end
      if (adv) begin
        vld[NSTAGE-1:1] <= vld[NSTAGE-2:0];
        result_valid    <= vld[NSTAGE-1];
      end
    end
  end

  // ---------------- stage 1: magnitudes and origin test ----------------
  logic [31:0] a_c, b_c, vx_c, vy_c;
  logic        near_c;
  logic [31:0] f1_a, f1_b, f1_vx, f1_vy;
  logic        f1_sp, f1_sq, f1_sx, f1_sy, f1_near;

  assign a_c  = item.pos_x[31] ? 32'd0 - item.pos_x : item.pos_x;
  assign b_c  = item.pos_y[31] ? 32'd0 - item.pos_y : item.pos_y;
  assign vx_c = item.vel_x[31] ? 32'd0 - item.vel_x : item.vel_x;
  assign vy_c = item.vel_y[31] ? 32'd0 - item.vel_y : item.vel_y;
  assign near_c = (a_c < 32'(limit) && b_c < 32'(limit)) || (a_c == '0 && b_c == '0);

  always_ff @(posedge clk) begin
    if (load0) begin
      f1_a    <= a_c;
      f1_b    <= b_c;
      f1_vx   <= vx_c;
      f1_vy   <= vy_c;
      f1_sp   <= item.pos_x[31];
      f1_sq   <= item.pos_y[31];
      f1_sx   <= item.vel_x[31];
      f1_sy   <= item.vel_y[31];
      f1_near <= near_c;
    end
  end

  // ---------------- stage 2: normalize so the larger magnitude reaches 2^30 ----------------
  logic [31:0] m_c;
  logic [4:0]  e_c;
  logic [31:0] f2_a, f2_b, f2_vx, f2_vy;
  logic [4:0]  f2_e;
  logic        f2_sp, f2_sq, f2_s1, f2_s2, f2_near;

  always_comb begin
    m_c = (f1_a > f1_b) ? f1_a : f1_b;
    e_c = '0;
    for (int i = 0; i < 32; i++) begin
      if (m_c[i]) begin
        e_c = (i >= 30) ? 5'd0 : 5'(30 - i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_a    <= f1_a << e_c;
      f2_b    <= f1_b << e_c;
      f2_e    <= e_c;
      f2_vx   <= f1_vx;
      f2_vy   <= f1_vy;
      f2_sp   <= f1_sp;
      f2_sq   <= f1_sq;
      f2_s1   <= f1_sx ^ f1_sq;
      f2_s2   <= f1_sy ^ f1_sp;
      f2_near <= f1_near;
    end
  end

  // ---------------- stage 3: squares and cross products ----------------
  logic [63:0] f3_aa, f3_bb, f3_m1, f3_m2;
  logic [31:0] f3_a, f3_b;
  logic [4:0]  f3_e;
  logic        f3_sp, f3_sq, f3_s1, f3_s2, f3_near;

  always_ff @(posedge clk) begin
    if (adv) begin
      f3_aa   <= 64'(f2_a) * 64'(f2_a);
      f3_bb   <= 64'(f2_b) * 64'(f2_b);
      f3_m1   <= 64'(f2_vx) * 64'(f2_b);
      f3_m2   <= 64'(f2_vy) * 64'(f2_a);
      f3_a    <= f2_a;
      f3_b    <= f2_b;
      f3_e    <= f2_e;
      f3_sp   <= f2_sp;
      f3_sq   <= f2_sq;
      f3_s1   <= f2_s1;
      f3_s2   <= f2_s2;
      f3_near <= f2_near;
    end
  end

  // ---------------- stage 4: r squared and the velocity cross term ----------------
  logic [64:0] d12_c;
  logic [63:0] wm_c;
  logic        sw_c;
  ctx_t        f4;

  assign d12_c = {1'b0, f3_m1} - {1'b0, f3_m2};

  always_comb begin
    if (f3_s1 != f3_s2) begin
      wm_c = f3_m1 + f3_m2;
      sw_c = f3_s1;
    end else if (!d12_c[64]) begin
      wm_c = d12_c[63:0];
      sw_c = f3_s1;
    end else begin
      wm_c = f3_m2 - f3_m1;
      sw_c = !f3_s1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f4.near  <= f3_near;
      f4.sp    <= f3_sp;
      f4.sq    <= f3_sq;
      f4.sw    <= sw_c;
      f4.e     <= f3_e;
      f4.a_n   <= f3_a;
      f4.b_n   <= f3_b;
      f4.s_sum <= f3_aa + f3_bb;
      f4.wm    <= wm_c;
    end
  end

  // ---------------- square root, one result bit per stage ----------------
  ctx_t              sq_ctx  [0:ROOT_W-1];
  logic [ROOT_W-1:0] sq_root [0:ROOT_W-1];
  logic [63:0]       sq_rem  [0:ROOT_W-2];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    localparam int J = ROOT_W - 1 - k;
    logic [ROOT_W-1:0] root_in;
    logic [63:0]       rem_in;
    ctx_t              ctx_in;
    logic [63:0]       trial;
    logic [64:0]       diff;

    if (k == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = f4.s_sum;
      assign ctx_in  = f4;
    end else begin : g_next
      assign root_in = sq_root[k-1];
      assign rem_in  = sq_rem[k-1];
      assign ctx_in  = sq_ctx[k-1];
    end

    // Root bits so far sit above J, so the two terms of the trial never overlap.
    assign trial = (64'(root_in) << (J + 1)) | (64'd1 << (2 * J));
    assign diff  = {1'b0, rem_in} - {1'b0, trial};

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_ctx[k]  <= ctx_in;
        sq_root[k] <= diff[64] ? root_in : (root_in | (ROOT_W'(1) << J));
      end
    end

    if (k < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          sq_rem[k] <= diff[64] ? rem_in : diff[63:0];
        end
      end
    end
  end

  // ---------------- px/r and py/r ----------------
  ctx_t             dx_ctx [0:DIV_LAT-1];
  logic [QUO_W-1:0] qx, qy;
  logic             ovx, ovy;

  rmj_div u_div_rx (
    .clk (clk),
    .en  (adv),
    .dvd (DVD_W'(sq_ctx[ROOT_W-1].a_n) << (FRAC_BITS + 1)),
    .dvs (DVS_W'(sq_root[ROOT_W-1])),
    .quo (qx),
    .ovf (ovx)
  );

  rmj_div u_div_ry (
    .clk (clk),
    .en  (adv),
    .dvd (DVD_W'(sq_ctx[ROOT_W-1].b_n) << (FRAC_BITS + 1)),
    .dvs (DVS_W'(sq_root[ROOT_W-1])),
    .quo (qy),
    .ovf (ovy)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_ctx[0] <= sq_ctx[ROOT_W-1];
      for (int i = 1; i < DIV_LAT; i++) begin
        dx_ctx[i] <= dx_ctx[i-1];
      end
    end
  end

  // ---------------- range row ----------------
  logic [QUO_W-1:0] rx_rnd, ry_rnd;
  logic [32:0]      rx_out, ry_out;
  ctx_t             xf;
  logic [RX_W-1:0]  xf_rx, xf_ry;
  logic [31:0]      xf_rdx, xf_rdy;
  logic             xf_sat;

  assign rx_rnd = round_q(qx);
  assign ry_rnd = round_q(qy);
  assign rx_out = clip_out(qx, ovx, dx_ctx[DIV_LAT-1].sp);
  assign ry_out = clip_out(qy, ovy, dx_ctx[DIV_LAT-1].sq);

  always_ff @(posedge clk) begin
    if (adv) begin
      xf     <= dx_ctx[DIV_LAT-1];
      xf_rx  <= rx_rnd[RX_W-1:0];
      xf_ry  <= ry_rnd[RX_W-1:0];
      xf_rdx <= rx_out[31:0];
      xf_rdy <= ry_out[31:0];
      xf_sat <= rx_out[32] | ry_out[32];
    end
  end

  // ---------------- (px/r, py/r) times the cross term, split in 32-bit halves ----------------
  ctx_t            p1;
  logic [PP_W-1:0] p1_xlo, p1_xhi, p1_ylo, p1_yhi;
  logic            p1_rx_nz, p1_ry_nz, p1_sat;
  logic [31:0]     p1_rdx, p1_rdy;

  always_ff @(posedge clk) begin
    if (adv) begin
      p1       <= xf;
      p1_xlo   <= PP_W'(xf_rx) * PP_W'(xf.wm[31:0]);
      p1_xhi   <= PP_W'(xf_rx) * PP_W'(xf.wm[63:32]);
      p1_ylo   <= PP_W'(xf_ry) * PP_W'(xf.wm[31:0]);
      p1_yhi   <= PP_W'(xf_ry) * PP_W'(xf.wm[63:32]);
      p1_rx_nz <= xf_rx != '0;
      p1_ry_nz <= xf_ry != '0;
      p1_rdx   <= xf_rdx;
      p1_rdy   <= xf_rdy;
      p1_sat   <= xf_sat;
    end
  end

  ctx_t           p2;
  logic [N_W-1:0] p2_nx, p2_ny;
  logic           p2_rx_nz, p2_ry_nz, p2_sat;
  logic [31:0]    p2_rdx, p2_rdy;

  always_ff @(posedge clk) begin
    if (adv) begin
      p2       <= p1;
      p2_nx    <= N_W'(p1_xlo) + (N_W'(p1_xhi) << 32);
      p2_ny    <= N_W'(p1_ylo) + (N_W'(p1_yhi) << 32);
      p2_rx_nz <= p1_rx_nz;
      p2_ry_nz <= p1_ry_nz;
      p2_rdx   <= p1_rdx;
      p2_rdy   <= p1_rdy;
      p2_sat   <= p1_sat;
    end
  end

  // ---------------- dividends and signs for bearing and rate terms ----------------
  logic [DVD_W-1:0] p3_dvd_bx, p3_dvd_by, p3_dvd_rx, p3_dvd_ry;
  logic [DVS_W-1:0] p3_dvs;
  ctxb_t            p3;

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_dvd_bx <= DVD_W'(p2.b_n) << (2 * FRAC_BITS + 1 + int'(p2.e));
      p3_dvd_by <= DVD_W'(p2.a_n) << (2 * FRAC_BITS + 1 + int'(p2.e));
      p3_dvd_rx <= DVD_W'(p2_ny) << (1 + int'(p2.e));
      p3_dvd_ry <= DVD_W'(p2_nx) << (1 + int'(p2.e));
      p3_dvs    <= p2.s_sum;
      p3.near   <= p2.near;
      p3.sat    <= p2_sat;
      p3.neg_bx <= !p2.sq && (p2.b_n != '0);
      p3.neg_by <= p2.sp && (p2.a_n != '0);
      p3.neg_rx <= (p2.sq != p2.sw) && p2_ry_nz && (p2.wm != '0);
      p3.neg_ry <= (p2.sp == p2.sw) && p2_rx_nz && (p2.wm != '0);
      p3.rdx    <= p2_rdx;
      p3.rdy    <= p2_rdy;
    end
  end

  ctxb_t            db_ctx [0:DIV_LAT-1];
  logic [QUO_W-1:0] qbx, qby, qrx, qry;
  logic             ovbx, ovby, ovrx, ovry;

  rmj_div u_div_bx (
    .clk (clk), .en (adv), .dvd (p3_dvd_bx), .dvs (p3_dvs), .quo (qbx), .ovf (ovbx)
  );
  rmj_div u_div_by (
    .clk (clk), .en (adv), .dvd (p3_dvd_by), .dvs (p3_dvs), .quo (qby), .ovf (ovby)
  );
  rmj_div u_div_tx (
    .clk (clk), .en (adv), .dvd (p3_dvd_rx), .dvs (p3_dvs), .quo (qrx), .ovf (ovrx)
  );
  rmj_div u_div_ty (
    .clk (clk), .en (adv), .dvd (p3_dvd_ry), .dvs (p3_dvs), .quo (qry), .ovf (ovry)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      db_ctx[0] <= p3;
      for (int i = 1; i < DIV_LAT; i++) begin
        db_ctx[i] <= db_ctx[i-1];
      end
    end
  end

  // ---------------- rounding, saturation and output register ----------------
  ctxb_t       fin;
  logic [32:0] bx_out, by_out, tx_out, ty_out;
  result_t     result_next;

  assign fin    = db_ctx[DIV_LAT-1];
  assign bx_out = clip_out(qbx, ovbx, fin.neg_bx);
  assign by_out = clip_out(qby, ovby, fin.neg_by);
  assign tx_out = clip_out(qrx, ovrx, fin.neg_rx);
  assign ty_out = clip_out(qry, ovry, fin.neg_ry);

  always_comb begin
    if (fin.near) begin
      result_next             = '0;
      result_next.near_origin = 1'b1;
    end else begin
      result_next.range_dx    = fin.rdx;
      result_next.range_dy    = fin.rdy;
      result_next.bearing_dx  = bx_out[31:0];
      result_next.bearing_dy  = by_out[31:0];
      result_next.rate_dx     = tx_out[31:0];
      result_next.rate_dy     = ty_out[31:0];
      result_next.near_origin = 1'b0;
      result_next.saturated   = fin.sat | bx_out[32] | by_out[32] | tx_out[32] | ty_out[32];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= result_next;
    end
  end

endmodule

/* src/rmj_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with an overflow check stage.
// Depends on rmj_pkg for its widths.
module rmj_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rmj_pkg::DVD_W-1:0]   dvd,
  input  logic [rmj_pkg::DVS_W-1:0]   dvs,
  output logic [rmj_pkg::QUO_W-1:0]   quo,
  output logic                        ovf
);
  import rmj_pkg::*;

  localparam int HI_W = DVD_W - QUO_W;

  logic [DVS_W-1:0] rem [0:QUO_W-1];
  logic [QUO_W-1:0] low [0:QUO_W-1];
  logic [DVS_W-1:0] dv  [0:QUO_W-1];
  logic [QUO_W-1:0] q   [0:QUO_W];
  logic             ov  [0:QUO_W];

  // The quotient fits in QUO_W bits only when the upper dividend part is below the divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      ov[0]  <= dvd[DVD_W-1:QUO_W] >= HI_W'(dvs);
      rem[0] <= dvd[QUO_W+DVS_W-1:QUO_W];
      low[0] <= dvd[QUO_W-1:0];
      dv[0]  <= dvs;
      q[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    assign trial = {rem[k-1], low[k-1][QUO_W-1]};
    assign diff  = trial - {1'b0, dv[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        q[k]  <= {q[k-1][QUO_W-2:0], ~diff[DVS_W]};
        ov[k] <= ov[k-1];
      end
    end

    if (k < QUO_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= diff[DVS_W] ? trial[DVS_W-1:0] : diff[DVS_W-1:0];
          low[k] <= {low[k-1][QUO_W-2:0], 1'b0};
          dv[k]  <= dv[k-1];
        end
      end
    end
  end

  assign quo = q[QUO_W];
  assign ovf = ov[QUO_W];

endmodule

/* src/rmj_checker.sv */
// Port-level checks for radar_measurement_jacobian_core, attached by the bind below.
// Depends on rmj_pkg for the result word type.
module rmj_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_stall,
  input logic             result_valid,
  input logic             result_stall,
  input rmj_pkg::result_t result
);
  import rmj_pkg::*;

  // A word held by the receiver stays put until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // With no word waiting at the output the pipeline moves, so the input is never stalled.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("input stalled while output is empty");

  // A word flagged near the origin carries an all-zero Jacobian and no clipping.
  a_origin_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.near_origin |->
      result.range_dx == '0 && result.range_dy == '0 &&
      result.bearing_dx == '0 && result.bearing_dy == '0 &&
      result.rate_dx == '0 && result.rate_dy == '0 && !result.saturated)
    else $error("near-origin word carries nonzero entries");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

bind radar_measurement_jacobian_core rmj_checker u_rmj_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

/* bench/radar_measurement_jacobian_core_tb.sv */
// Self-checking testbench for radar_measurement_jacobian_core: random and directed state words,
// predicted Jacobian words compared field by field. Depends on rmj_pkg and the core's sources.
`timescale 1ns / 100ps
module radar_measurement_jacobian_core_tb;
  import rmj_pkg::*;

  localparam int FRAC = 16;
  localparam int DRAIN_CYCLES = 150;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  item_t item;
  logic result_valid;
  logic result_stall;
  result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [LIMIT_W-1:0] cfg_data;

  radar_measurement_jacobian_core #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  item_t state_queue[$];
  result_t jacobian_queue[$];
  logic [LIMIT_W-1:0] origin_limit;
  int errors;
  int words_in;
  int words_out;
  int near_count;
  int sat_count;
  int idle_cycles;
  bit timed_out;
  bit state_taken;
  bit jac_taken;
  int send_gap;
  int recv_gap;
  bit no_idle;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Mostly short gaps, now and then a long one; no gaps at all while no_idle is set.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [127:0] t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = (r | (64'd1 << i)) * (r | (64'd1 << i));
      if (t <= {64'd0, v}) r = r | (64'd1 << i);
    end
    return r;
  endfunction

  // Rounded (n * 2^k / d) with halves up in magnitude, clipped by sign; returns {clipped, value}.
  function automatic logic [32:0] round_div(input logic [255:0] n, input int k,
                                            input logic [63:0] d, input bit neg);
    logic [255:0] q;
    logic [255:0] cap;
    bit clip;
    q = (((n << (k + 1)) / {192'd0, d}) + 1) >> 1;
    cap = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
    clip = q > cap;
    if (clip) q = cap;
    return {clip, neg ? (32'd0 - q[31:0]) : q[31:0]};
  endfunction

  function automatic result_t jacobian_of(input item_t s);
    result_t j;
    logic [63:0] a, b, vxm, vym, mx, ax, by, sq, rt, m1, m2, wm;
    logic [32:0] rx, ry, t;
    bit nx, ny, nvx, nvy, s1, s2, sw, clip;
    int e;
    j = '0;
    nx = s.pos_x[31]; ny = s.pos_y[31]; nvx = s.vel_x[31]; nvy = s.vel_y[31];
    a = nx ? 64'(-{32'd0, s.pos_x}) & 64'hFFFF_FFFF : {32'd0, s.pos_x};
    b = ny ? 64'(-{32'd0, s.pos_y}) & 64'hFFFF_FFFF : {32'd0, s.pos_y};
    vxm = nvx ? 64'(-{32'd0, s.vel_x}) & 64'hFFFF_FFFF : {32'd0, s.vel_x};
    vym = nvy ? 64'(-{32'd0, s.vel_y}) & 64'hFFFF_FFFF : {32'd0, s.vel_y};
    if ((a < origin_limit && b < origin_limit) || (a == 0 && b == 0)) begin
      j.near_origin = 1'b1;
      return j;
    end
    mx = (a > b) ? a : b;
    e = 0;
    while ((mx << e) < (64'd1 << 30)) e++;
    ax = a << e;
    by = b << e;
    sq = ax * ax + by * by;
    rt = isqrt(sq);
    clip = 0;
    rx = round_div({192'd0, ax}, FRAC, rt, 1'b0);
    ry = round_div({192'd0, by}, FRAC, rt, 1'b0);
    j.range_dx = nx ? -rx[31:0] : rx[31:0];
    j.range_dy = ny ? -ry[31:0] : ry[31:0];
    t = round_div({192'd0, by}, 2 * FRAC + e, sq, !ny && by != 0);
    j.bearing_dx = t[31:0]; clip |= t[32];
    t = round_div({192'd0, ax}, 2 * FRAC + e, sq, nx && ax != 0);
    j.bearing_dy = t[31:0]; clip |= t[32];
    // Sign and magnitude of vx*py - vy*px.
    m1 = vxm * by; s1 = (nvx != ny);
    m2 = vym * ax; s2 = (nvy != nx);
    if (s1 != s2) begin
      wm = m1 + m2; sw = s1;
    end else if (m1 >= m2) begin
      wm = m1 - m2; sw = s1;
    end else begin
      wm = m2 - m1; sw = !s1;
    end
    t = round_div({192'd0, ry[31:0]} * {192'd0, wm}, e, sq,
                  (ny != sw) && ry[31:0] != 0 && wm != 0);
    j.rate_dx = t[31:0]; clip |= t[32];
    t = round_div({192'd0, rx[31:0]} * {192'd0, wm}, e, sq,
                  (nx == sw) && rx[31:0] != 0 && wm != 0);
    j.rate_dy = t[31:0]; clip |= t[32];
    j.saturated = clip;
    return j;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Rising edge: take accepted words, predict, check and keep the watchdog.
  always @(posedge clk) begin
    result_t want;
    state_taken = 1'b0;
    jac_taken = 1'b0;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        state_taken = 1'b1;
        words_in++;
        jacobian_queue.push_back(jacobian_of(item));
      end
      if (result_valid && !result_stall) begin
        jac_taken = 1'b1;
        words_out++;
        if (jacobian_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual %h", $time, result);
        end else begin
          want = jacobian_queue.pop_front();
          if (want.near_origin) near_count++;
          if (want.saturated) sat_count++;
          check_field("range_dx", want.range_dx, result.range_dx);
          check_field("range_dy", want.range_dy, result.range_dy);
          check_field("bearing_dx", want.bearing_dx, result.bearing_dx);
          check_field("bearing_dy", want.bearing_dy, result.bearing_dy);
          check_field("rate_dx", want.rate_dx, result.rate_dx);
          check_field("rate_dy", want.rate_dy, result.rate_dy);
          check_field("near_origin", 32'(want.near_origin), 32'(result.near_origin));
          check_field("saturated", 32'(want.saturated), 32'(result.saturated));
        end
      end
      if (state_taken || jac_taken || (state_queue.size() == 0 && !item_valid
          && jacobian_queue.size() == 0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d words outstanding", $time,
                 jacobian_queue.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Falling edge: the sender and the receiver's stall.
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      result_stall <= 1'b0;
    end else begin
      if (!item_valid || state_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (state_queue.size() > 0) begin
          item <= state_queue.pop_front();
          item_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          item_valid <= 1'b0;
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
        recv_gap = pick_gap();
      end
    end
  end

  function automatic logic [31:0] rand_field();
    int r;
    r = $urandom_range(9);
    if (r < 4) return $urandom;
    if (r < 6) return 32'($signed($urandom_range(0, 4000)) - 2000);
    if (r < 8) return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    if (r == 8) return {$urandom_range(1) ? 2'b10 : 2'b01, 30'($urandom)};
    return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  task automatic add_state(input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] vx, input logic [31:0] vy);
    item_t s;
    s.pos_x = px; s.pos_y = py; s.vel_x = vx; s.vel_y = vy;
    state_queue.push_back(s);
  endtask

  task automatic add_random(input int count);
    logic [31:0] px, py;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(9);
      px = rand_field();
      py = rand_field();
      // Some positions sit right around the origin limit.
      if (r == 0) px = 32'($signed($urandom_range(0, 2 * origin_limit + 2)) - origin_limit - 1);
      if (r == 1) py = 32'($signed($urandom_range(0, 2 * origin_limit + 2)) - origin_limit - 1);
      add_state(px, py, rand_field(), rand_field());
    end
  endtask

  // Lets the pipeline empty, then writes a new origin limit.
  task automatic set_limit(input logic [LIMIT_W-1:0] val);
    wait (state_queue.size() == 0 && !item_valid && jacobian_queue.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    origin_limit = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [LIMIT_W-1:0] limits[4];
    errors = 0; words_in = 0; words_out = 0; near_count = 0; sat_count = 0;
    idle_cycles = 0; send_gap = 0; recv_gap = 0; no_idle = 0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    origin_limit = LIMIT_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words: origin, limit edges, field extremes and clipping cases.
    add_state(32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    add_state(32'd65, -32'sd65, 32'd1, 32'd1);
    add_state(32'd66, 32'd0, 32'd1 << 16, 32'd0);
    add_state(32'd0, -32'sd66, 32'd0, 32'd1 << 16);
    add_state(32'd1, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000);
    add_state(32'h8000_0000, 32'd0, 32'd0, 32'h7FFF_FFFF);
    add_state(32'd0, 32'h8000_0000, 32'h8000_0000, 32'd0);
    add_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_state(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    add_state(32'd67, 32'd67, 32'h7FFF_FFFF, 32'h8000_0000);
    add_state(-32'sd67, 32'd1, 32'h8000_0000, 32'h8000_0000);
    add_state(32'd3 << 16, 32'd4 << 16, 32'd1 << 16, -32'sd1 << 16);
    add_state(-32'sd3 << 16, -32'sd4 << 16, 32'd2 << 16, 32'd5 << 16);
    add_state(32'd1 << 16, 32'd1 << 16, 32'd1 << 16, 32'd1 << 16);
    add_state(32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0);
    add_random(380);

    limits[0] = '0;
    limits[1] = 17'd65536;
    limits[2] = 17'h1_FFFF;
    limits[3] = 17'($urandom_range(1, 5000));
    for (int p = 0; p < 4; p++) begin
      set_limit(limits[p]);
      if (p == 0) begin
        add_state(32'd0, 32'd0, 32'd5, 32'd5);
        add_state(32'd1, 32'd0, 32'd5, 32'd5);
        add_state(32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd5);
      end
      no_idle = (p == 2);
      add_random(300);
    end
    set_limit(LIMIT_RESET);
    no_idle = 0;
    add_random(100);

    wait (state_queue.size() == 0 && !item_valid && jacobian_queue.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d of %0d state words under five origin limits; %0d near the origin,",
             words_out, words_in, near_count);
    $display("%0d with a clipped entry, %0d errors.", sat_count, errors);
    if (errors == 0 && jacobian_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
